FILE: sv/assert_macros.svh
// Assertion macros used by the tlfp_checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: sv/tlfp_pkg.sv
package tlfp_pkg;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_EMPTY   = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic REG_SHORT_TYPES = 1'b0;
    localparam logic REG_MAX_PAYLOAD = 1'b1;

    localparam logic [63:0] SHORT_TYPES_RESET = 64'd1023;
    localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd65535;

    localparam logic [2:0] SHORT_LEN_BYTES = 3'd2;
    localparam logic [2:0] LONG_LEN_BYTES  = 3'd4;
    localparam logic [7:0] MASKED_TYPES    = 8'd64;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  frame_type;
        logic [7:0]  payload_byte;
        logic        last;
        logic [31:0] frame_length;
    } result_t;

endpackage

FILE: sv/type_length_frame_parser.sv
// Channel   Direction  Handshake             Payload
// in        to block   in_valid / in_stall   data_byte
// out       from block out_valid / out_stall kind, frame_type, payload_byte, last,
//                                            frame_length
// cfg       to block   APB write/read        paddr, pwdata, prdata
//
// One byte per cycle unless in_stall: a byte updates the frame state as it is taken.
// A result is registered when its byte is accepted, into the output register if free.
// A second result is caught in a skid register while out_stall holds the first;
// in_stall rises only while that skid register is full.
// rst_n clears the frame state and result registers and resets the configuration.
module type_length_frame_parser
    import tlfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  frame_type,
    output logic [7:0]  payload_byte,
    output logic        last,
    output logic [31:0] frame_length,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    typedef enum logic [1:0] {
        PH_TYPE = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2,
        PH_ERR  = 2'd3
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  type_reg, type_next;
    logic [2:0]  len_left_reg, len_left_next;
    logic [31:0] accum_reg, accum_next;
    logic [31:0] payload_left_reg, payload_left_next;

    logic [63:0] short_types_reg;
    logic [31:0] max_payload_reg;

    result_t     out_reg, skid_reg, res;
    logic        out_valid_reg, skid_valid_reg;
    logic        res_valid;

    logic        in_accept;
    logic        out_free;
    logic        type_is_short;
    logic [31:0] accum_shift;
    logic [2:0]  len_left_dec;
    logic [31:0] payload_dec;
    logic        cfg_write;
    logic        cfg_sel;

    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    assign type_is_short = (data_byte < MASKED_TYPES) && short_types_reg[data_byte[5:0]];
    assign accum_shift   = {accum_reg[23:0], data_byte};
    assign len_left_dec  = len_left_reg - 3'd1;
    assign payload_dec   = payload_left_reg - 32'd1;

    always_comb
    begin
        phase_next        = phase_reg;
        type_next         = type_reg;
        len_left_next     = len_left_reg;
        accum_next        = accum_reg;
        payload_left_next = payload_left_reg;
        res_valid         = 1'b0;
        res.kind          = KIND_PAYLOAD;
        res.payload_byte  = 8'd0;
        res.last          = 1'b1;
        case (phase_reg)
            PH_TYPE:
            begin
                type_next     = data_byte;
                len_left_next = type_is_short ? SHORT_LEN_BYTES : LONG_LEN_BYTES;
                accum_next    = 32'd0;
                phase_next    = PH_LEN;
            end
            PH_LEN:
            begin
                accum_next    = accum_shift;
                len_left_next = len_left_dec;
                if (len_left_dec == 3'd0)
                begin
                    if (accum_shift > max_payload_reg)
                    begin
                        phase_next = PH_ERR;
                        res_valid  = 1'b1;
                        res.kind   = KIND_ERROR;
                    end
                    else if (accum_shift == 32'd0)
                    begin
                        phase_next = PH_TYPE;
                        res_valid  = 1'b1;
                        res.kind   = KIND_EMPTY;
                    end
                    else
                    begin
                        payload_left_next = accum_shift;
                        phase_next        = PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                payload_left_next = payload_dec;
                res_valid         = 1'b1;
                res.kind          = KIND_PAYLOAD;
                res.payload_byte  = data_byte;
                res.last          = (payload_dec == 32'd0);
                if (payload_dec == 32'd0)
                begin
                    phase_next = PH_TYPE;
                end
            end
            default:
            begin
                phase_next = PH_ERR;
            end
        endcase
        res.frame_type   = type_reg;
        res.frame_length = accum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_TYPE;
            type_reg         <= 8'd0;
            len_left_reg     <= 3'd0;
            accum_reg        <= 32'd0;
            payload_left_reg <= 32'd0;
            out_valid_reg    <= 1'b0;
            skid_valid_reg   <= 1'b0;
            out_reg          <= '0;
            skid_reg         <= '0;
        end
        else
        begin
            if (in_accept)
            begin
                phase_reg        <= phase_next;
                type_reg         <= type_next;
                len_left_reg     <= len_left_next;
                accum_reg        <= accum_next;
                payload_left_reg <= payload_left_next;
            end
            if (out_free)
            begin
                // drain the skid stage first; no request is taken while it is full
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    out_reg        <= skid_reg;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= in_accept && res_valid;
                    out_reg       <= res;
                end
            end
            else if (in_accept && res_valid)
            begin
                skid_valid_reg <= 1'b1;
                skid_reg       <= res;
            end
        end
    end

    assign cfg_write = psel && penable && pwrite;
    assign cfg_sel   = paddr[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_types_reg <= SHORT_TYPES_RESET;
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_sel == REG_SHORT_TYPES)
            begin
                short_types_reg <= pwdata;
            end
            else
            begin
                max_payload_reg <= pwdata[31:0];
            end
        end
    end

    assign prdata = (cfg_sel == REG_MAX_PAYLOAD) ? {32'd0, max_payload_reg} : short_types_reg;
    assign pready = 1'b1;

    assign out_valid    = out_valid_reg;
    assign kind         = out_reg.kind;
    assign frame_type   = out_reg.frame_type;
    assign payload_byte = out_reg.payload_byte;
    assign last         = out_reg.last;
    assign frame_length = out_reg.frame_length;

endmodule

FILE: sv/tlfp_checker.sv
`include "assert_macros.svh"

module tlfp_checker
    import tlfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  kind,
    input  logic [7:0]  payload_byte,
    input  logic        last,
    input  logic [31:0] frame_length
);

    // hold a stalled result
    `ASSERT_ALWAYS(a_out_hold, out_valid && out_stall |=> out_valid && $stable(kind) && $stable(frame_length), "stalled result changed")

    `ASSERT_NEVER(a_marker_shape, out_valid && kind != KIND_PAYLOAD && (!last || payload_byte != 8'd0), "empty or error result malformed")

    `ASSERT_NEVER(a_empty_len, out_valid && kind == KIND_EMPTY && frame_length != 32'd0, "empty frame with nonzero length")

    `ASSERT_NEVER(a_single_last, out_valid && kind == KIND_PAYLOAD && frame_length == 32'd1 && !last, "one-byte frame not flagged last")

    // drop everything after a length error
    `ASSERT_ALWAYS(a_err_silent, out_valid && !out_stall && kind == KIND_ERROR |=> !out_valid, "result after length error")

endmodule

bind type_length_frame_parser tlfp_checker u_tlfp_checker (.*);

FILE: bench/frame_result_checker.sv
module frame_result_checker
    import tlfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  data_byte,

    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  kind,
    input  logic [7:0]  frame_type,
    input  logic [7:0]  payload_byte,
    input  logic        last,
    input  logic [31:0] frame_length,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,

    output int          mismatches,
    output int          pending
);

    typedef enum logic [1:0] {
        AWAIT_TYPE,
        READ_LENGTH,
        READ_PAYLOAD,
        DROP_ALL
    } parse_phase_t;

    logic [63:0]  short_types;
    logic [31:0]  max_payload;
    parse_phase_t phase;
    logic [7:0]   cur_type;
    logic [2:0]   length_left;
    logic [31:0]  length_acc;
    logic [31:0]  payload_left;
    result_t      expected_results [$];
    int           mismatch_count;

    task automatic queue_result(input logic [1:0] k, input logic [7:0] b, input logic l);
        result_t r;
        r.kind         = k;
        r.frame_type   = cur_type;
        r.payload_byte = b;
        r.last         = l;
        r.frame_length = length_acc;
        expected_results.push_back(r);
    endtask

    task automatic parse_byte(input logic [7:0] b);
        case (phase)
            AWAIT_TYPE:
            begin
                cur_type    = b;
                length_left = (b < MASKED_TYPES && short_types[b[5:0]]) ?
                              SHORT_LEN_BYTES : LONG_LEN_BYTES;
                length_acc  = '0;
                phase       = READ_LENGTH;
            end
            READ_LENGTH:
            begin
                length_acc  = {length_acc[23:0], b};
                length_left = length_left - 3'd1;
                if (length_left == 3'd0)
                begin
                    if (length_acc > max_payload)
                    begin
                        phase = DROP_ALL;
                        queue_result(KIND_ERROR, 8'd0, 1'b1);
                    end
                    else if (length_acc == 32'd0)
                    begin
                        phase = AWAIT_TYPE;
                        queue_result(KIND_EMPTY, 8'd0, 1'b1);
                    end
                    else
                    begin
                        payload_left = length_acc;
                        phase        = READ_PAYLOAD;
                    end
                end
            end
            READ_PAYLOAD:
            begin
                payload_left = payload_left - 32'd1;
                queue_result(KIND_PAYLOAD, b, payload_left == 32'd0);
                if (payload_left == 32'd0)
                    phase = AWAIT_TYPE;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_result();
        result_t seen;
        result_t want;
        seen = '{kind, frame_type, payload_byte, last, frame_length};
        if (expected_results.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected result: kind=%0d type=%0d byte=%0d last=%0d length=%0d",
                         seen.kind, seen.frame_type, seen.payload_byte, seen.last,
                         seen.frame_length);
        end
        else
        begin
            want = expected_results.pop_front();
            if (seen.kind !== want.kind || seen.frame_type !== want.frame_type ||
                seen.payload_byte !== want.payload_byte || seen.last !== want.last ||
                seen.frame_length !== want.frame_length)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("result mismatch: expected kind=%0d type=%0d byte=%0d last=%0d len=%0d",
                             want.kind, want.frame_type, want.payload_byte, want.last,
                             want.frame_length);
                    $display("                 got      kind=%0d type=%0d byte=%0d last=%0d len=%0d",
                             seen.kind, seen.frame_type, seen.payload_byte, seen.last,
                             seen.frame_length);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_types    = SHORT_TYPES_RESET;
            max_payload    = MAX_PAYLOAD_RESET;
            phase          = AWAIT_TYPE;
            cur_type       = '0;
            length_left    = '0;
            length_acc     = '0;
            payload_left   = '0;
            mismatch_count = 0;
            expected_results.delete();
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == {REG_SHORT_TYPES, 3'b000})
                    short_types = pwdata;
                else if (paddr == {REG_MAX_PAYLOAD, 3'b000})
                    max_payload = pwdata[31:0];
            end
            if (in_valid && !in_stall)
                parse_byte(data_byte);
            if (out_valid && !out_stall)
                check_result();
            mismatches <= mismatch_count;
            pending    <= expected_results.size();
        end
    end

endmodule

FILE: bench/type_length_frame_parser_tb.sv
module type_length_frame_parser_tb;
    import tlfp_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  frame_type;
    logic [7:0]  payload_byte;
    logic        last;
    logic [31:0] frame_length;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'd0;
    logic [63:0] pwdata = 64'd0;
    logic [63:0] prdata;
    logic        pready;

    int          mismatches;
    int          pending;

    logic [63:0] cfg_short_types = SHORT_TYPES_RESET;
    logic [31:0] cfg_max_payload = MAX_PAYLOAD_RESET;
    int          gap_odds = 6;
    logic        stall_enable = 1'b1;
    int          bytes_sent = 0;
    int          stall_left = 0;
    int          flow_left = 0;

    logic [7:0]  opening_bytes [23] = '{
        8'd0,   8'h00, 8'h01, 8'h00,
        8'd9,   8'h00, 8'h02, 8'hFF, 8'hA5,
        8'd10,  8'h00, 8'h00, 8'h00, 8'h00,
        8'd255, 8'h00, 8'h00, 8'h00, 8'h01, 8'h5A,
        8'd0,   8'h00, 8'h00
    };

    type_length_frame_parser u_dut (.*);

    frame_result_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .frame_type   (frame_type),
        .payload_byte (payload_byte),
        .last         (last),
        .frame_length (frame_length),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (!stall_enable)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 1)
            stall_left <= stall_left - 1;
        else if (stall_left == 1)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
            flow_left  <= $urandom_range(0, 24);
        end
        else if (flow_left > 0)
            flow_left <= flow_left - 1;
        else if ($urandom_range(0, 3) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(1, 18);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] t, input logic [31:0] len);
        int len_bytes;
        len_bytes = (t < MASKED_TYPES && cfg_short_types[t[5:0]]) ?
                    SHORT_LEN_BYTES : LONG_LEN_BYTES;
        send_byte(t);
        for (int i = len_bytes - 1; i >= 0; i--)
            send_byte(len[8*i +: 8]);
        for (int unsigned i = 0; i < len; i++)
            send_byte(8'($urandom));
    endtask

    task automatic wait_drained(input int settle);
        int quiet_cycles;
        int waited;
        quiet_cycles = 0;
        waited = 0;
        in_valid <= 1'b0;
        while (quiet_cycles < settle && waited < 20000)
        begin
            @(posedge clk);
            waited++;
            if (pending == 0)
                quiet_cycles++;
            else
                quiet_cycles = 0;
        end
    endtask

    task automatic write_reg(input logic [3:0] addr, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        int          phase_start;
        int          frame_no;
        int          pick;
        logic [7:0]  t;
        logic [31:0] len;
        logic [31:0] len_cap;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_bytes[i])
            send_byte(opening_bytes[i]);

        for (int p = 1; p <= 5; p++)
        begin
            wait_drained(4);
            case (p)
                1:
                begin
                    cfg_short_types = 64'd0;
                    cfg_max_payload = 32'hFFFF_FFFF;
                end
                2:
                begin
                    cfg_short_types = '1;
                    cfg_max_payload = 32'd0;
                end
                3:
                begin
                    cfg_short_types = {$urandom, $urandom};
                    cfg_max_payload = $urandom_range(1, 16);
                end
                4:
                begin
                    cfg_short_types = {$urandom, $urandom};
                    cfg_max_payload = {1'b1, 31'($urandom)};
                end
                default:
                begin
                    cfg_short_types = SHORT_TYPES_RESET;
                    cfg_max_payload = $urandom_range(1, 16);
                end
            endcase
            write_reg({REG_SHORT_TYPES, 3'b000}, cfg_short_types);
            write_reg({REG_MAX_PAYLOAD, 3'b000}, {32'd0, cfg_max_payload});

            gap_odds     = (p == 2 || p == 5) ? 0 : 6;
            stall_enable = (p != 5);

            phase_start = bytes_sent;
            frame_no = 0;
            while (bytes_sent - phase_start < 140)
            begin
                if (frame_no == 0)
                    t = 8'd63;
                else if (frame_no == 1)
                    t = 8'd64;
                else if ($urandom_range(0, 1) == 1)
                    t = 8'($urandom_range(0, 63));
                else
                    t = 8'($urandom);

                len_cap = (cfg_max_payload < 32'd12) ? cfg_max_payload : 32'd12;
                pick = $urandom_range(0, 7);
                if (cfg_max_payload == 32'd0 || pick == 0)
                    len = 32'd0;
                else if (pick == 1 && cfg_max_payload <= 32'd16)
                    len = cfg_max_payload;
                else
                    len = $urandom_range(1, len_cap);

                send_frame(t, len);
                frame_no++;
            end
            if (p == 1)
                send_frame(8'd200, 32'($urandom_range(256, 300)));
        end

        // a declared length above the limit locks the parser until reset
        wait_drained(4);
        send_byte(8'($urandom_range(64, 255)));
        repeat (4) send_byte(8'hFF);
        repeat (8) send_byte(8'($urandom));
        wait_drained(8);

        if (mismatches == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
